### sv/b64d_pkg.sv
// Shared types, constants and the character classifier for the base64 decoder.
package b64d_pkg;

  localparam int unsigned PADDR_W = 1;
  localparam int unsigned PDATA_W = 32;

  // Register byte addresses
  localparam logic [PADDR_W-1:0] REG_STRICT_MODE = '0;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_PAD = 8'h3D;

  typedef enum logic [1:0] {
    CLS_DATA,
    CLS_SKIP,
    CLS_ILLEGAL
  } cls_kind_t;

  typedef struct packed {
    cls_kind_t  kind;
    logic [5:0] value;
  } cls_t;

  // Maps a character to its 6-bit value, or marks it as whitespace / illegal.
  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r.kind  = CLS_DATA;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.value = 6'd63;
    end else if (c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h20) begin
      r.kind = CLS_SKIP;
    end else begin
      r.kind = CLS_ILLEGAL;
    end
    return r;
  endfunction

endpackage

### sv/base64_decoder_strict.sv
// Base64 decoder with strict/lenient checking, one character per beat.
//
// Usage:
//  - Input channel: in_valid / in_stall carry in_byte and in_last, one encoded
//    character per beat. Result channel: res_valid / res_stall carry out_byte,
//    out_valid, out_last and out_error.
//  - A result beat is sent for every decoded byte and for the character marked
//    in_last; whitespace, pads and ignored characters send nothing.
//  - out_error is meaningful on the last beat of a string: 1 if it was rejected.
//  - strict_mode is written through the APB port at address 0. The user
//    writes it only while idle; the block itself does not enforce this.
//  - One character per cycle unless a result beat is stalled. The decode is a
//    small lookup plus a shift between the input and the result register.
//  - Reset clears the decode state and strict_mode; no beats are pending.
//  - When the receiver stalls, the result register holds its beat; a character
//    that yields a result then waits in the input register with in_stall high.
//    Characters that yield no result still drain while the result side stalls.
//  - After the last character the decode state returns to reset; strict_mode
//    is kept.
module base64_decoder_strict (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          in_last,
  // result channel
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [7:0]                    out_byte,
  output logic                          out_valid,
  output logic                          out_last,
  output logic                          out_error,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [b64d_pkg::PADDR_W-1:0]  paddr,
  input  logic [b64d_pkg::PDATA_W-1:0]  pwdata,
  output logic [b64d_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic       strict_mode;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // decode state
  logic [1:0] phase, phase_next;
  logic [7:0] partial_bits, partial_bits_next;
  logic       pad_seen, pad_seen_next;
  logic       error_seen, error_seen_next;
  logic       terminated, terminated_next;

  logic       dec_valid;
  logic [7:0] dec_byte;
  logic       produce;
  logic       advance;
  logic       s1_done;
  b64d_pkg::cls_t cls;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == b64d_pkg::REG_STRICT_MODE) prdata[0] = strict_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == b64d_pkg::REG_STRICT_MODE) begin
      strict_mode <= pwdata[0];
    end
  end

  // ---------------- handshake ----------------
  assign produce  = dec_valid || s1_last;
  // the stage empties when it yields nothing or the result register can take it
  assign advance  = !produce || !res_valid || !res_stall;
  assign s1_done  = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= in_byte;
      s1_last <= in_last;
    end
  end

  // ---------------- decode ----------------
  assign cls = b64d_pkg::classify(s1_byte);

  always_comb begin
    phase_next        = phase;
    partial_bits_next = partial_bits;
    pad_seen_next     = pad_seen;
    error_seen_next   = error_seen;
    terminated_next   = terminated;
    dec_valid         = 1'b0;
    dec_byte          = 8'd0;
    if (!terminated && !error_seen) begin
      if (s1_byte == b64d_pkg::CH_NUL) begin
        terminated_next = 1'b1;
      end else if (s1_byte == b64d_pkg::CH_PAD) begin
        // a pad right after the first character of a group is never legal
        if (phase == 2'd1) error_seen_next = 1'b1;
        else               pad_seen_next   = 1'b1;
      end else begin
        unique case (cls.kind)
          b64d_pkg::CLS_SKIP: ;
          b64d_pkg::CLS_ILLEGAL: begin
            if (strict_mode) error_seen_next = 1'b1;
          end
          b64d_pkg::CLS_DATA: begin
            if (strict_mode && pad_seen) begin
              error_seen_next = 1'b1;
            end else begin
              unique case (phase)
                2'd0: partial_bits_next = {cls.value, 2'b00};
                2'd1: begin
                  dec_byte          = partial_bits | {6'd0, cls.value[5:4]};
                  partial_bits_next = {cls.value[3:0], 4'd0};
                  dec_valid         = 1'b1;
                end
                2'd2: begin
                  dec_byte          = partial_bits | {4'd0, cls.value[5:2]};
                  partial_bits_next = {cls.value[1:0], 6'd0};
                  dec_valid         = 1'b1;
                end
                default: begin
                  dec_byte  = partial_bits | {2'd0, cls.value};
                  dec_valid = 1'b1;
                end
              endcase
              phase_next = phase + 2'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 2'd0;
      partial_bits <= 8'd0;
      pad_seen     <= 1'b0;
      error_seen   <= 1'b0;
      terminated   <= 1'b0;
    end else if (s1_done) begin
      if (s1_last) begin
        phase        <= 2'd0;
        partial_bits <= 8'd0;
        pad_seen     <= 1'b0;
        error_seen   <= 1'b0;
        terminated   <= 1'b0;
      end else begin
        phase        <= phase_next;
        partial_bits <= partial_bits_next;
        pad_seen     <= pad_seen_next;
        error_seen   <= error_seen_next;
        terminated   <= terminated_next;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_done && produce) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && produce) begin
      out_byte  <= dec_byte;
      out_valid <= dec_valid;
      out_last  <= s1_last;
      out_error <= s1_last && error_seen_next;
    end
  end

  // ---------------- assertions ----------------
  a_error_only_last: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!out_error || out_last))
    else $error("error flag on a beat that is not last");

  a_byte_zero_when_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_valid) |-> (out_byte == 8'd0))
    else $error("nonzero byte on a beat without data");

  a_state_clears_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_done && s1_last) |=> (phase == 2'd0 && !error_seen && !pad_seen && !terminated))
    else $error("decode state not cleared after last character");

  a_no_data_after_stop: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (terminated || error_seen)) |-> !dec_valid)
    else $error("byte decoded after string was stopped");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the strict/lenient base64 decoder.
module tb_top;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       error;
  } dec_result_t;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     in_byte;
  logic                           in_last;
  logic                           res_valid;
  logic                           res_stall;
  logic [7:0]                     out_byte;
  logic                           out_valid;
  logic                           out_last;
  logic                           out_error;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [b64d_pkg::PADDR_W-1:0]   paddr;
  logic [b64d_pkg::PDATA_W-1:0]   pwdata;
  logic [b64d_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  base64_decoder_strict dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last),
    .out_error (out_error),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // decoder shadow state
  logic       strict_q;
  logic [1:0] dec_phase;
  logic [7:0] dec_bits;
  logic       pad_q;
  logic       err_q;
  logic       term_q;

  dec_result_t decoded_q[$];
  dec_result_t want_r;

  int fail_count;
  int chars_sent;
  int strings_sent;
  int results_seen;
  int cfg_writes;
  int gap_pct;
  int stall_pct;
  int hold_len;
  logic [1:0] strict_used;
  logic       in_stall_seen;

  logic [7:0] ws_chars [4] = '{8'h09, 8'h0A, 8'h0D, 8'h20};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] sextet_char(input int unsigned v);
    if (v < 26) return 8'(8'h41 + v);
    if (v < 52) return 8'(8'h61 + v - 26);
    if (v < 62) return 8'(8'h30 + v - 52);
    if (v == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  task automatic sort_char(input logic [7:0] c, output b64d_pkg::cls_kind_t kind,
                           output logic [5:0] v);
    kind = b64d_pkg::CLS_DATA;
    v = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) v = 6'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) v = 6'(c - 8'h61 + 26);
    else if (c >= 8'h30 && c <= 8'h39) v = 6'(c - 8'h30 + 52);
    else if (c == 8'h2B) v = 6'd62;
    else if (c == 8'h2F) v = 6'd63;
    else if (c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h20) kind = b64d_pkg::CLS_SKIP;
    else kind = b64d_pkg::CLS_ILLEGAL;
  endtask

  task automatic clear_decode();
    dec_phase = 2'd0;
    dec_bits  = 8'h00;
    pad_q     = 1'b0;
    err_q     = 1'b0;
    term_q    = 1'b0;
  endtask

  // Advance the shadow decoder by one accepted character.
  task automatic decode_char(input logic [7:0] c, input logic last);
    b64d_pkg::cls_kind_t kind;
    logic [5:0]  v;
    dec_result_t r;
    r = '0;
    sort_char(c, kind, v);
    if (!term_q && !err_q) begin
      if (c == b64d_pkg::CH_NUL) begin
        term_q = 1'b1;
      end else if (c == b64d_pkg::CH_PAD) begin
        if (dec_phase == 2'd1) err_q = 1'b1;
        else pad_q = 1'b1;
      end else if (kind == b64d_pkg::CLS_ILLEGAL) begin
        if (strict_q) err_q = 1'b1;
      end else if (kind == b64d_pkg::CLS_DATA) begin
        if (strict_q && pad_q) begin
          err_q = 1'b1;
        end else begin
          case (dec_phase)
            2'd0: dec_bits = {v, 2'b00};
            2'd1: begin
              r.data   = dec_bits | {6'b0, v[5:4]};
              dec_bits = {v[3:0], 4'h0};
              r.valid  = 1'b1;
            end
            2'd2: begin
              r.data   = dec_bits | {4'b0, v[5:2]};
              dec_bits = {v[1:0], 6'h00};
              r.valid  = 1'b1;
            end
            default: begin
              r.data  = dec_bits | {2'b0, v};
              r.valid = 1'b1;
            end
          endcase
          dec_phase = dec_phase + 2'd1;
        end
      end
    end
    if (r.valid || last) begin
      r.last  = last;
      r.error = last && err_q;
      decoded_q.push_back(r);
    end
    if (last) clear_decode();
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (decoded_q.size() == 0) begin
        $error("result beat with nothing expected: out_byte 0x%0h", out_byte);
        fail_count++;
      end else begin
        want_r = decoded_q.pop_front();
        check_field("out_byte", want_r.data, out_byte);
        check_field("out_valid", want_r.valid, out_valid);
        check_field("out_last", want_r.last, out_last);
        check_field("out_error", want_r.error, out_error);
        results_seen++;
      end
    end
  end

  // Receiver side: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_len > 0) begin
      res_stall <= 1'b1;
      hold_len = hold_len - 1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= c;
    in_last  <= last;
    do begin
      @(posedge clk);
      if (in_stall) in_stall_seen = 1'b1;
    end while (in_stall);
    chars_sent++;
    decode_char(c, last);
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++) send_char(s[i], i == s.size() - 1);
    strings_sent++;
  endtask

  // Stop offering, wait out every expected beat, then let in-flight characters settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_strict(input logic value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= b64d_pkg::REG_STRICT_MODE;
    pwdata  <= b64d_pkg::PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    strict_q = value;
    strict_used[value] = 1'b1;
    cfg_writes++;
    // back-to-back read of the same register
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", b64d_pkg::PDATA_W'(value), prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_string();
    logic [7:0] s[$];
    int kind;
    int pos;
    int cut;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(9) == 0) s.push_back(ws_chars[$urandom_range(3)]);
          s.push_back(sextet_char($urandom_range(63)));
        end
      end
      cut = $urandom_range(3);
      if (cut == 1) begin
        s[s.size()-1] = b64d_pkg::CH_PAD;
      end else if (cut == 2) begin
        s[s.size()-1] = b64d_pkg::CH_PAD;
        s[s.size()-2] = b64d_pkg::CH_PAD;
      end else if (cut == 3) begin
        void'(s.pop_back());
      end
      if (kind < 40) begin
        pos = $urandom_range(s.size() - 1);
        case ($urandom_range(3))
          0: s[pos] = 8'($urandom_range(255));
          1: s.insert(pos, b64d_pkg::CH_PAD);
          2: s.insert(pos, b64d_pkg::CH_NUL);
          default: begin
            s.push_back(b64d_pkg::CH_PAD);
            s.push_back(sextet_char($urandom_range(63)));
          end
        endcase
      end
    end
    send_string(s);
  endtask

  task automatic test_lenient_cases();
    write_strict(1'b0);
    // "Q x=A" with 0xFF, then "B": whitespace, pad followed by data, illegal skipped
    send_string('{8'h51, 8'h20, 8'h78, 8'h3D, 8'h41, 8'hFF, 8'h42});
    // pad at phase 1 rejects even when lenient
    send_string('{8'h51, 8'h3D});
    drain();
  endtask

  task automatic test_strict_cases();
    write_strict(1'b1);
    // "/+9<tab>=z": data after a pad
    send_string('{8'h2F, 8'h2B, 8'h39, 8'h09, 8'h3D, 8'h7A});
    // illegal character, rest ignored
    send_string('{8'h41, 8'h80, 8'h41});
    // NUL ends decoding early
    send_string('{8'h41, 8'h42, 8'h00, 8'h43, 8'h44});
    // "g<lf>7": ends mid-group, leftover bits dropped
    send_string('{8'h67, 8'h0A, 8'h37});
    drain();
  endtask

  task automatic test_random_traffic(input int send_gap, input int recv_stall, input int n_items);
    int start;
    int chunk;
    gap_pct   = send_gap;
    stall_pct = recv_stall;
    start = chars_sent;
    chunk = 0;
    while (chars_sent - start < n_items) begin
      if (chunk % 6 == 0) begin
        drain();
        write_strict(1'($urandom_range(1)));
      end
      send_random_string();
      chunk++;
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering; input must back up.
  task automatic test_result_hold_off();
    logic [7:0] s[$];
    gap_pct   = 0;
    stall_pct = 0;
    write_strict(1'b1);
    repeat (40) s.push_back(sextet_char($urandom_range(63)));
    @(posedge clk);
    hold_len = 150;
    send_string(s);
    drain();
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    in_last  = 1'b0;
    res_stall = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    fail_count = 0;
    chars_sent = 0;
    strings_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    gap_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    strict_used = 2'b00;
    in_stall_seen = 1'b0;
    strict_q = 1'b0;
    clear_decode();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_lenient_cases();
    test_strict_cases();
    test_random_traffic(24, 79, 255);
    test_random_traffic(79, 24, 255);
    test_random_traffic(0, 0, 255);
    test_result_hold_off();

    $display("Sent %0d characters in %0d strings, checked %0d result beats.",
             chars_sent, strings_sent, results_seen);
    $display("Modes used (strict/lenient): %0b/%0b, %0d register writes,",
             strict_used[1], strict_used[0], cfg_writes);
    $display("input backpressure seen: %0b.", in_stall_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/b64d_pkg.sv
sv/base64_decoder_strict.sv
tb/tb_top.sv
